/* hw/rtl/wri_pkg.sv */
// Shared types, constants and control bundles for the Wilder RSI block.
package wri_pkg;

  // Default parameter values.
  localparam int MAX_PERIOD_DEF    = 64;
  localparam int PRICE_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int PRICE_FIELD_W = 32;
  localparam int PERIOD_W      = 7;
  localparam int LEVEL_W       = 15;
  localparam int RSI_W         = 15;
  localparam int ZONE_W        = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 15;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 7'd14;
  localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RESET = 15'd17920;
  localparam logic [LEVEL_W-1:0]  OVERSOLD_RESET   = 15'd7680;

  // RSI scale in Q.8.
  localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;
  localparam logic [RSI_W-1:0] RSI_HALF = 15'd12800;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERBOUGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERSOLD   = 2'd2;

  // Zone codes.
  localparam logic [ZONE_W-1:0] ZONE_NEUTRAL    = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_OVERBOUGHT = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_OVERSOLD   = 2'd2;

  typedef struct packed {
    logic [PRICE_FIELD_W-1:0] price_sample;
    logic                     sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [RSI_W-1:0]  rsi_value;
    logic              rsi_ready;
    logic [ZONE_W-1:0] zone;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_INIT,
    DIV_WILDER,
    DIV_RSI
  } div_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_G,
    S_DIVS_G,
    S_WAIT_G,
    S_MUL_L,
    S_DIVS_L,
    S_WAIT_L,
    S_RSI_MUL,
    S_RSI_DIVS,
    S_RSI_WAIT,
    S_PUSH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    mul_wilder;
    logic    mul_rsi;
    logic    div_start;
    div_op_e div_op;
    logic    sel_loss;
    logic    write_avg;
    logic    set_started;
    logic    res_not_ready;
    logic    res_half;
    logic    write_rsi;
    logic    push;
  } wri_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first;
    logic started;
    logic form;
    logic total_zero;
    logic div_done;
    logic out_free;
  } wri_status_t;

endpackage

/* hw/rtl/wri_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module wri_div #(
  parameter int DW       = 63,
  parameter int DVW      = 49,
  parameter int QW       = 48,
  parameter int SHORT_QB = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           long_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [QW-1:0]  quotient_o
);

  localparam int CNTW = $clog2(QW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DVW-1:0]  rem_q;
  logic [DVW-1:0]  div_q;
  logic [QW-1:0]   dq_q;

  logic [DVW:0]   partial;
  logic [DVW+1:0] diff;
  logic           qbit;
  logic [DVW-1:0] rem_d;

  // Trial subtract of the divisor from the shifted remainder.
  always_comb begin
    partial = {rem_q, dq_q[QW-1]};
    diff    = {1'b0, partial} - {2'b00, div_q};
    qbit    = ~diff[DVW+1];
    rem_d   = qbit ? diff[DVW-1:0] : partial[DVW-1:0];
  end

  // Control: busy flag, step counter, done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= long_i ? CNTW'(QW) : CNTW'(SHORT_QB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: high dividend bits seed the remainder, the rest shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      if (long_i) begin
        rem_q <= DVW'(dividend_i >> QW);
        dq_q  <= dividend_i[QW-1:0];
      end else begin
        rem_q <= DVW'(dividend_i >> SHORT_QB);
        dq_q  <= {dividend_i[SHORT_QB-1:0], {(QW-SHORT_QB){1'b0}}};
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[QW-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

/* hw/rtl/wri_datapath.sv */
// Datapath: configuration, price history, sums, averages, multiplier, divider, output register.
module wri_datapath #(
  parameter int MAX_PERIOD    = wri_pkg::MAX_PERIOD_DEF,
  parameter int PRICE_BITS    = wri_pkg::PRICE_BITS_DEF,
  parameter int FRACTION_BITS = wri_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic [wri_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [wri_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wri_pkg::in_item_t                   in_data_i,
  input  wri_pkg::wri_cmd_t                   cmd_i,
  output wri_pkg::wri_status_t                status_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output wri_pkg::out_item_t                  out_data_o
);

  localparam int PW   = PRICE_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int PCAP = (MAX_PERIOD < 127) ? MAX_PERIOD : 127;
  localparam int SW   = PW + $clog2(PCAP + 1);
  localparam int AW   = PW + FB;
  localparam int DW   = AW + wri_pkg::RSI_W;
  localparam int DVW  = AW + 1;
  localparam int PRW  = wri_pkg::PERIOD_W;

  // Configuration registers.
  logic [PRW-1:0]                period_q;
  logic [wri_pkg::LEVEL_W-1:0]   overbought_q;
  logic [wri_pkg::LEVEL_W-1:0]   oversold_q;

  // Running state.
  logic [PW-1:0]  last_price_q;
  logic           have_last_q;
  logic [PRW-1:0] count_q;
  logic [SW-1:0]  gain_sum_q;
  logic [SW-1:0]  loss_sum_q;
  logic [AW-1:0]  avg_gain_q;
  logic [AW-1:0]  avg_loss_q;
  logic           started_q;

  // Per-item working registers.
  logic           first_q;
  logic           form_q;
  logic [PW-1:0]  gain_q;
  logic [PW-1:0]  loss_q;
  logic [DW-1:0]  prod_q;
  wri_pkg::out_item_t res_q;
  wri_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic [PW+wri_pkg::PRICE_FIELD_W-1:0] price_ext;
  logic [PW-1:0]  price;
  logic           up;
  logic [PW-1:0]  gain_d;
  logic [PW-1:0]  loss_d;
  logic [PRW-1:0] count_inc;
  logic [PRW-1:0] p_eff;

  logic [AW-1:0]            mul_a;
  logic [wri_pkg::RSI_W-1:0] mul_b;
  logic [PW-1:0]            x_sel;
  logic [AW-1:0]            x_shift;
  logic [DW-1:0]            mul_p;
  logic [DW-1:0]            mul_add;
  logic [SW-1:0]            sum_sel;

  logic [DW-1:0]  div_dividend;
  logic [DVW-1:0] div_divisor;
  logic           div_long;
  logic           div_done;
  logic [AW-1:0]  quot;
  logic [DVW-1:0] total;

  logic [wri_pkg::RSI_W-1:0]  rsi_new;
  logic [wri_pkg::ZONE_W-1:0] zone_new;
  logic                       out_free;

  // Take the low price bits, zero-extended when the datapath is wider.
  assign price_ext = {{PW{1'b0}}, in_data_i.price_sample};
  assign price     = price_ext[PW-1:0];

  // Change against the previous valid sample.
  always_comb begin
    up        = (price >= last_price_q);
    gain_d    = up ? (price - last_price_q) : '0;
    loss_d    = up ? '0 : (last_price_q - price);
    count_inc = count_q + 1'b1;
  end

  // Effective period: zero acts as one, clamp at the maximum.
  always_comb begin
    p_eff = period_q;
    if (p_eff == '0) begin
      p_eff = PRW'(1);
    end
    if (int'(p_eff) > MAX_PERIOD) begin
      p_eff = PRW'(MAX_PERIOD);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= wri_pkg::PERIOD_RESET;
      overbought_q <= wri_pkg::OVERBOUGHT_RESET;
      oversold_q   <= wri_pkg::OVERSOLD_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        wri_pkg::CFG_PERIOD: begin
          period_q <= cfg_data_i[PRW-1:0];
        end
        wri_pkg::CFG_OVERBOUGHT: begin
          overbought_q <= cfg_data_i;
        end
        wri_pkg::CFG_OVERSOLD: begin
          oversold_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Running state: history, warm-up sums, averages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_price_q <= '0;
      have_last_q  <= 1'b0;
      count_q      <= '0;
      gain_sum_q   <= '0;
      loss_sum_q   <= '0;
      avg_gain_q   <= '0;
      avg_loss_q   <= '0;
      started_q    <= 1'b0;
      first_q      <= 1'b0;
      form_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        last_price_q <= price;
        have_last_q  <= 1'b1;
        first_q      <= ~have_last_q;
        form_q       <= 1'b0;
        if (have_last_q && !started_q) begin
          gain_sum_q <= gain_sum_q + SW'(gain_d);
          loss_sum_q <= loss_sum_q + SW'(loss_d);
          count_q    <= count_inc;
          form_q     <= (count_inc >= p_eff);
        end
      end
      if (cmd_i.write_avg) begin
        if (cmd_i.sel_loss) begin
          avg_loss_q <= quot;
        end else begin
          avg_gain_q <= quot;
        end
      end
      if (cmd_i.set_started) begin
        started_q <= 1'b1;
      end
    end
  end

  // Hold this item's change.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gain_q <= gain_d;
      loss_q <= loss_d;
    end
  end

  // Shared multiplier: avg*(p-1) + x*2^FB for smoothing, G*25600 for the index.
  always_comb begin
    mul_a   = cmd_i.sel_loss ? avg_loss_q : avg_gain_q;
    x_sel   = cmd_i.sel_loss ? loss_q : gain_q;
    x_shift = {x_sel, {FB{1'b0}}};
    mul_b   = cmd_i.mul_rsi ? wri_pkg::RSI_FULL : wri_pkg::RSI_W'(p_eff - 1'b1);
    mul_p   = mul_a * mul_b;
    mul_add = cmd_i.mul_wilder ? DW'(x_shift) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_wilder || cmd_i.mul_rsi) begin
      prod_q <= mul_p + mul_add;
    end
  end

  // Divider operand selection.
  assign total = {1'b0, avg_gain_q} + {1'b0, avg_loss_q};

  always_comb begin
    sum_sel = cmd_i.sel_loss ? loss_sum_q : gain_sum_q;
    unique case (cmd_i.div_op)
      wri_pkg::DIV_INIT: begin
        div_dividend = DW'({sum_sel, {FB{1'b0}}});
        div_divisor  = DVW'(count_q);
        div_long     = 1'b1;
      end
      wri_pkg::DIV_WILDER: begin
        div_dividend = prod_q;
        div_divisor  = DVW'(p_eff);
        div_long     = 1'b1;
      end
      default: begin
        div_dividend = prod_q;
        div_divisor  = total;
        div_long     = 1'b0;
      end
    endcase
  end

  wri_div #(
    .DW      (DW),
    .DVW     (DVW),
    .QW      (AW),
    .SHORT_QB(wri_pkg::RSI_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .long_i    (div_long),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  // Index value and zone; overbought takes priority.
  always_comb begin
    rsi_new = cmd_i.res_half ? wri_pkg::RSI_HALF : quot[wri_pkg::RSI_W-1:0];
    priority if (rsi_new > overbought_q) begin
      zone_new = wri_pkg::ZONE_OVERBOUGHT;
    end else if (rsi_new < oversold_q) begin
      zone_new = wri_pkg::ZONE_OVERSOLD;
    end else begin
      zone_new = wri_pkg::ZONE_NEUTRAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_not_ready) begin
      res_q.rsi_value <= '0;
      res_q.rsi_ready <= 1'b0;
      res_q.zone      <= wri_pkg::ZONE_NEUTRAL;
    end else if (cmd_i.write_rsi || cmd_i.res_half) begin
      res_q.rsi_value <= rsi_new;
      res_q.rsi_ready <= 1'b1;
      res_q.zone      <= zone_new;
    end
  end

  // Output register: load on push, drop once the transfer completes.
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.first      = first_q;
    status_o.started    = started_q;
    status_o.form       = form_q;
    status_o.total_zero = (total == '0);
    status_o.div_done   = div_done;
    status_o.out_free   = out_free;
  end

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result pushed over an untaken transfer");

  a_rsi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.rsi_value <= wri_pkg::RSI_FULL) &&
                    (out_q.rsi_ready || (out_q.zone == wri_pkg::ZONE_NEUTRAL)))
    else $error("result out of range");

endmodule

/* hw/rtl/wri_ctrl.sv */
// Controller state machine sequencing the per-sample arithmetic.
module wri_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 item_valid_i,
  output logic                 in_stall_o,
  input  wri_pkg::wri_status_t status_i,
  output wri_pkg::wri_cmd_t    cmd_o
);

  wri_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wri_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.div_op = status_i.started ? wri_pkg::DIV_WILDER : wri_pkg::DIV_INIT;
    in_stall_o = 1'b1;
    unique case (state_q)
      wri_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && item_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wri_pkg::S_DISPATCH;
        end
      end
      wri_pkg::S_DISPATCH: begin
        priority if (status_i.first) begin
          cmd_o.res_not_ready = 1'b1;
          state_d             = wri_pkg::S_PUSH;
        end else if (status_i.started) begin
          state_d = wri_pkg::S_MUL_G;
        end else if (status_i.form) begin
          state_d = wri_pkg::S_DIVS_G;
        end else begin
          cmd_o.res_not_ready = 1'b1;
          state_d             = wri_pkg::S_PUSH;
        end
      end
      wri_pkg::S_MUL_G: begin
        cmd_o.mul_wilder = 1'b1;
        state_d          = wri_pkg::S_DIVS_G;
      end
      wri_pkg::S_DIVS_G: begin
        cmd_o.div_start = 1'b1;
        state_d         = wri_pkg::S_WAIT_G;
      end
      wri_pkg::S_WAIT_G: begin
        if (status_i.div_done) begin
          cmd_o.write_avg = 1'b1;
          state_d = status_i.started ? wri_pkg::S_MUL_L : wri_pkg::S_DIVS_L;
        end
      end
      wri_pkg::S_MUL_L: begin
        cmd_o.sel_loss   = 1'b1;
        cmd_o.mul_wilder = 1'b1;
        state_d          = wri_pkg::S_DIVS_L;
      end
      wri_pkg::S_DIVS_L: begin
        cmd_o.sel_loss  = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = wri_pkg::S_WAIT_L;
      end
      wri_pkg::S_WAIT_L: begin
        cmd_o.sel_loss = 1'b1;
        if (status_i.div_done) begin
          cmd_o.write_avg   = 1'b1;
          cmd_o.set_started = 1'b1;
          state_d           = wri_pkg::S_RSI_MUL;
        end
      end
      wri_pkg::S_RSI_MUL: begin
        if (status_i.total_zero) begin
          cmd_o.res_half = 1'b1;
          state_d        = wri_pkg::S_PUSH;
        end else begin
          cmd_o.mul_rsi = 1'b1;
          state_d       = wri_pkg::S_RSI_DIVS;
        end
      end
      wri_pkg::S_RSI_DIVS: begin
        cmd_o.div_op    = wri_pkg::DIV_RSI;
        cmd_o.div_start = 1'b1;
        state_d         = wri_pkg::S_RSI_WAIT;
      end
      wri_pkg::S_RSI_WAIT: begin
        cmd_o.div_op = wri_pkg::DIV_RSI;
        if (status_i.div_done) begin
          cmd_o.write_rsi = 1'b1;
          state_d         = wri_pkg::S_PUSH;
        end
      end
      wri_pkg::S_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = wri_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wri_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/wilder_rsi_indicator_unit.sv */
// Top level: Wilder relative strength index over a stream of price samples.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one price
// sample per transfer. A sample flagged not valid is absorbed in its
// transfer cycle and yields nothing. Every valid sample yields exactly one
// result on the output channel (out_valid_o / out_stall_i / out_data_o).
// The first sample and all warm-up samples give a not-ready result.
// A not-ready result goes straight to the output register; a smoothing
// update runs a multiply and a divide for the gain average, then for the
// loss average, then for the index. The iterative divider, one quotient
// bit per cycle, does most of that work; one sample is in flight at a
// time, so the next sample is taken only once the last result is pushed.
// A finished result sits in an output register, so the next sample is
// taken while the receiver stalls; a second finished result then waits
// inside the block until the register frees up.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken.
// Reset clears history, warm-up sums and averages, and loads the default
// period of 14 and thresholds of 70 and 30 (Q.8).
module wilder_rsi_indicator_unit #(
  parameter int MAX_PERIOD    = wri_pkg::MAX_PERIOD_DEF,
  parameter int PRICE_BITS    = wri_pkg::PRICE_BITS_DEF,
  parameter int FRACTION_BITS = wri_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wri_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [wri_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wri_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wri_pkg::out_item_t              out_data_o
);

  wri_pkg::wri_cmd_t    cmd;
  wri_pkg::wri_status_t status;

  assign cfg_ready_o = 1'b1;

  wri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .item_valid_i(in_data_i.sample_valid),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wri_datapath #(
    .MAX_PERIOD   (MAX_PERIOD),
    .PRICE_BITS   (PRICE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_write_i(cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule
